FILE: rtl/sipt_pkg.sv
package sipt_pkg;

   localparam int DEPTH   = 32;
   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   // parity class: {odd, negative odd}; 0, 1 and -1 map to distinct codes
   typedef logic [1:0] class_type;

   typedef struct packed {
      logic insert;
      logic shift_out;
   } cell_ctrl_type;

   typedef struct packed {
      logic step;
      logic done;
   } drain_stat_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   function automatic class_type parity_class(value_type v);
      parity_class = {v[0], v[0] & v[VALUE_W-1]};
   endfunction

endpackage

FILE: rtl/sipt_req_if.sv
interface sipt_req_if import sipt_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type in_value;
   logic      in_last;

   modport source (output valid, output in_value, output in_last, input ready);
   modport sink (input valid, input in_value, input in_last, output ready);
endinterface

FILE: rtl/sipt_rsp_if.sv
interface sipt_rsp_if import sipt_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type out_value;
   logic      out_last;
   logic      overflow;

   modport source (output valid, output out_value, output out_last, output overflow,
                   input ready);
   modport sink (input valid, input out_value, input out_last, input overflow,
                 output ready);
endinterface

FILE: rtl/sipt_cell.sv
module sipt_cell import sipt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  value_type     ins_value,
   input  value_type     left_value,
   input  logic          left_valid,
   input  logic          left_take,
   input  value_type     right_value,
   input  logic          right_valid,
   output value_type     value,
   output logic          valid,
   output logic          take
);

   value_type value_ff, value_in;
   logic      valid_ff, valid_in;

   // empty cells and cells holding a value >= the new one give way
   assign take = !valid_ff || (value_ff >= ins_value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.insert) begin
         if (left_take) begin
            value_in = left_value;
            valid_in = left_valid;
         end else if (take) begin
            value_in = ins_value;
            valid_in = 1'b1;
         end
      end else if (ctrl.shift_out) begin
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

FILE: rtl/sipt_drain.sv
module sipt_drain import sipt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           draining,
   input  value_type      head_value,
   input  logic           head_valid,
   input  logic           thin_en,
   input  logic           dropped,
   output drain_stat_type stat,
   sipt_rsp_if.source     rsp
);

   value_type pend_value_ff, pend_value_in;
   logic      pend_valid_ff, pend_valid_in;
   class_type pend_class_ff, pend_class_in;
   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_value_ff, rsp_value_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_ovf_ff, rsp_ovf_in;
   logic      out_free;
   logic      keep;
   class_type head_class;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign head_class = parity_class(head_value);
   assign keep       = !thin_en || !pend_valid_ff || (head_class != pend_class_ff);

   always_comb begin
      stat.step     = draining && out_free && head_valid;
      stat.done     = draining && out_free && !head_valid;
      pend_value_in = pend_value_ff;
      pend_valid_in = pend_valid_ff;
      pend_class_in = pend_class_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      // a kept entry waits in pend until the next kept one shows it is not last
      if (stat.step && keep) begin
         pend_value_in = head_value;
         pend_valid_in = 1'b1;
         pend_class_in = head_class;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = pend_value_ff;
            rsp_last_in  = 1'b0;
            rsp_ovf_in   = dropped;
         end
      end else if (stat.done) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_value_in  = pend_value_ff;
         rsp_last_in   = 1'b1;
         rsp_ovf_in    = dropped;
      end
   end

   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
      pend_class_ff <= pend_class_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_value = rsp_value_ff;
   assign rsp.out_last  = rsp_last_ff;
   assign rsp.overflow  = rsp_ovf_ff;

endmodule

FILE: rtl/sorted_insert_parity_thinning.sv
// values enter one per cycle while filling; each is placed into the cell chain in that cycle,
// or dropped and flagged as overflow when the chain is full; after the beat marked last the
// chain drains one cell per cycle through the thinning stage: a kept value waits in a pending
// register and then moves to the result register, thinned values give no beat, a waiting
// result beat stalls the drain; a set drains fully before input is taken again
// synchronous active-high reset empties the chain, clears the overflow flag, thin_enable = 1
module sorted_insert_parity_thinning import sipt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sipt_req_if.sink   req_if,
   sipt_rsp_if.source rsp_if,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   state_type      state_ff, state_in;
   logic           thin_ff, thin_in;
   logic           dropped_ff, dropped_in;
   logic           accept;
   logic           full;
   cell_ctrl_type  ctrl;
   drain_stat_type dstat;

   value_type cell_value [DEPTH];
   logic      cell_valid [DEPTH];
   logic      cell_take  [DEPTH];

   assign full   = cell_valid[DEPTH-1];
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      state_in      = state_ff;
      dropped_in    = dropped_ff;
      req_if.ready  = 1'b0;
      ctrl.insert   = 1'b0;
      ctrl.shift_out = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            req_if.ready = 1'b1;
            if (accept) begin
               ctrl.insert = !full;
               if (full) begin
                  dropped_in = 1'b1;
               end
               if (req_if.in_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            ctrl.shift_out = dstat.step;
            if (dstat.done) begin
               dropped_in = 1'b0;
               state_in   = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   assign thin_in = csr_wr_en ? csr_wr_data : thin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         thin_ff    <= 1'b1;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         thin_ff    <= thin_in;
         dropped_ff <= dropped_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      value_type lv, rv;
      logic      lval, ltake, rval;
      if (i == 0) begin : g_first
         assign lv    = '0;
         assign lval  = 1'b0;
         assign ltake = 1'b0;
      end else begin : g_mid
         assign lv    = cell_value[i-1];
         assign lval  = cell_valid[i-1];
         assign ltake = cell_take[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rv   = '0;
         assign rval = 1'b0;
      end else begin : g_inner
         assign rv   = cell_value[i+1];
         assign rval = cell_valid[i+1];
      end
      sipt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .ins_value   (req_if.in_value),
         .left_value  (lv),
         .left_valid  (lval),
         .left_take   (ltake),
         .right_value (rv),
         .right_valid (rval),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .take        (cell_take[i])
      );
   end

   sipt_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .draining   (state_ff == ST_DRAIN),
      .head_value (cell_value[0]),
      .head_valid (cell_valid[0]),
      .thin_en    (thin_ff),
      .dropped    (dropped_ff),
      .stat       (dstat),
      .rsp        (rsp_if)
   );

endmodule

FILE: dv/tb.sv
module tb import sipt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam value_type VMIN = 32'sh8000_0000;
   localparam value_type VMAX = 32'sh7fff_ffff;
   localparam int SETTLE_CYCLES = DEPTH + 4;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_ITEMS = 450;

   typedef struct {
      value_type value;
      logic      last;
      logic      ovf;
   } sorted_beat_type;

   class sort_scoreboard;
      value_type       sorted_q[$];
      bit              dropped;
      bit              thin_on = 1'b1;
      sorted_beat_type pending_q[$];
      int              mismatches;
      int              accepted;

      function void report(string what, sorted_beat_type want, value_type v, logic last,
                           logic ovf);
         mismatches++;
         if (mismatches <= 10)
            $display("%t %s: expected value %0d last %0b overflow %0b, %s %0d %s %0b %s %0b",
                     $realtime, what, want.value, want.last, want.ovf,
                     "got value", v, "last", last, "overflow", ovf);
      endfunction

      function void note_input(value_type v, logic last);
         int              pos;
         int              rem;
         int              prev_rem;
         value_type       kept[$];
         sorted_beat_type b;
         accepted++;
         if (sorted_q.size() >= DEPTH) begin
            dropped = 1'b1;
         end else begin
            pos = 0;
            while (pos < sorted_q.size() && sorted_q[pos] < v) pos++;
            sorted_q.insert(pos, v);
         end
         if (!last) return;
         prev_rem = 0;
         foreach (sorted_q[i]) begin
            // truncating remainder: negative odd values get -1
            rem = int'(sorted_q[i] % 2);
            if (thin_on && kept.size() > 0 && rem == prev_rem) continue;
            kept.push_back(sorted_q[i]);
            prev_rem = rem;
         end
         foreach (kept[i]) begin
            b.value = kept[i];
            b.last  = (i == kept.size() - 1);
            b.ovf   = dropped;
            pending_q.push_back(b);
         end
         sorted_q.delete();
         dropped = 1'b0;
      endfunction

      function void check_result(value_type v, logic last, logic ovf);
         sorted_beat_type want;
         if (pending_q.size() == 0) begin
            want.value = 'x;
            want.last  = 1'bx;
            want.ovf   = 1'bx;
            report("unexpected beat", want, v, last, ovf);
            return;
         end
         want = pending_q.pop_front();
         if (want.value !== v || want.last !== last || want.ovf !== ovf)
            report("mismatch", want, v, last, ovf);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   sipt_req_if req_bus ();
   sipt_rsp_if rsp_bus ();

   sort_scoreboard sb;
   value_type      dir_q[$];
   value_type      recent_q[$];
   bit             sender_burst;

   sorted_insert_parity_thinning u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic value_type pick_value();
      int        r;
      value_type v;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         v = $urandom;
      end else if (r < 65) begin
         v = int'($urandom_range(0, 16)) - 8;
      end else if (r < 75) begin
         case ($urandom_range(0, 3))
            0: v = VMIN;
            1: v = VMAX;
            2: v = VMIN + 1;
            default: v = VMAX - 1;
         endcase
      end else if (r < 90 && recent_q.size() > 0) begin
         v = recent_q[$urandom_range(0, recent_q.size() - 1)];
      end else begin
         v = -int'($urandom_range(1, 1000));
      end
      recent_q.push_back(v);
      if (recent_q.size() > 16) void'(recent_q.pop_front());
      return v;
   endfunction

   task automatic send_item(value_type v, logic last);
      int gap;
      gap = sender_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.in_value <= v;
      req_bus.in_last  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_input(v, last);
   endtask

   task automatic send_dir();
      sender_burst = 1'b0;
      foreach (dir_q[i]) send_item(dir_q[i], i == dir_q.size() - 1);
   endtask

   task automatic send_set(int n);
      sender_burst = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
   endtask

   // wait for the list to drain, then let the chain go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_thin(bit on);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.thin_on = on;
   endtask

   initial begin
      int n;
      int r;
      int sent;
      int total;
      int phase;
      sb = new();
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= 1'b0;
      req_bus.valid    <= 1'b0;
      req_bus.in_value <= '0;
      req_bus.in_last  <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // thinning on from reset
      dir_q = '{5};
      send_dir();
      dir_q = '{3, 3};
      send_dir();
      dir_q = '{VMAX, VMIN, 0, -1, 1, -3, 2, VMIN};
      send_dir();
      dir_q = '{-7, -5, 4, 6, 1};
      send_dir();
      settle();
      write_thin(1'b0);
      dir_q = '{-1, -1, VMIN, VMAX, 0, 1};
      send_dir();

      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         settle();
         write_thin(phase % 2 == 0);
         sent = 0;
         while (sent < 90) begin
            r = $urandom_range(0, 99);
            if (r < 70) n = $urandom_range(1, 6);
            else if (r < 92) n = $urandom_range(7, 20);
            else n = $urandom_range(DEPTH - 2, DEPTH + 8);
            send_set(n);
            sent += n;
         end
         total += sent;
         phase++;
      end

      settle();
      if (sb.mismatches == 0)
         $display("sorted_insert_parity_thinning regression: pass");
      else
         $display("sorted_insert_parity_thinning regression: fail");
      $finish;
   end

   // result side: check each beat, stall at random, one long hold-off
   initial begin
      int  idle_left;
      int  run_left;
      int  hold_left;
      bit  hold_done;
      idle_left = 0;
      run_left  = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.out_value, rsp_bus.out_last, rsp_bus.overflow);
         if (!hold_done && sb.accepted >= 60) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_bus.ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
            run_left  = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 12);
            idle_left = pick_gap();
         end
      end
   end

   initial begin
      #20_000_000;
      $display("sorted_insert_parity_thinning regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sipt_pkg.sv
rtl/sipt_req_if.sv
rtl/sipt_rsp_if.sv
rtl/sipt_cell.sv
rtl/sipt_drain.sv
rtl/sorted_insert_parity_thinning.sv
dv/tb.sv
